// ----- rtl/mme_pkg.sv -----
// Shared constants and types for the matrix multiply engine.
// No dependencies; imported by the multiply-accumulate unit and the top level.
`default_nettype none

package mme_pkg;

  // Fixed field widths of the item ports
  localparam int IDX_W      = 6;
  localparam int VAL_W      = 16;
  localparam int RES_W      = 40;
  localparam int SIZE_W     = 7;
  localparam int FUNC_W     = 2;
  localparam int SIZE_RESET = 64;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WR_A = 2'd0,
    FUNC_WR_B = 2'd1,
    FUNC_ROW  = 2'd2
  } func_e;

  // Operand qualifiers travelling with each read issued to the matrix stores
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/mme_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the A and B element stores.
`default_nettype none

module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/mme_mac.sv -----
// Shared multiply-accumulate unit: aligns qualifiers with the RAM read data,
// registers the product, then accumulates. Depends on mme_pkg.
`default_nettype none

module mme_mac
  import mme_pkg::*;
#(
  parameter int EW = 16,
  localparam int ACC_W = 2 * EW + 6
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire mac_ctrl_t               ctrl_i,
  input  wire logic signed [EW-1:0]    a_i,
  input  wire logic signed [EW-1:0]    b_i,
  output logic signed      [ACC_W-1:0] acc_o,
  output logic                         done_o
);

  mac_ctrl_t                 rd_ctl_q;
  mac_ctrl_t                 p_ctl_q;
  logic signed [2*EW-1:0]    prod_d;
  logic signed [2*EW-1:0]    prod_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic                      done_q;

  assign prod_d = a_i * b_i;

  // Qualifiers follow the data one stage per register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ctl_q <= '0;
      p_ctl_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      rd_ctl_q <= ctrl_i;
      p_ctl_q  <= rd_ctl_q;
      done_q   <= p_ctl_q.valid & p_ctl_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (p_ctl_q.valid) begin
      // restart the sum on the first term of each column
      acc_q <= p_ctl_q.first ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// ----- rtl/matrix_multiply_engine.sv -----
// Top level of the matrix multiply engine: element stores, row sequencer and
// output register. Depends on mme_pkg, mme_ram and mme_mac.
`default_nettype none

// Computes C = A x B for square signed Q8.8 matrices of size n (size_n, clamped
// to 1..min(MAX_N, 64)). An A or B element write is taken only while idle. A row
// request for row i returns n transfers, columns 0 to n-1, each the exact
// Q24.16 dot product of A row i and B column j, with last on the final one.
// A row request holds the input until its last column is loaded: one multiply-
// accumulate unit takes one term per cycle from the single read port of each
// element store, and each column adds a pipeline drain and hand-over, plus
// waiting while the output is stalled. Elements read that were never written
// give undefined results; the stores need no clearing after reset.
module matrix_multiply_engine
  import mme_pkg::*;
#(
  parameter int MAX_N  = 64,
  parameter int ELEM_W = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [SIZE_W-1:0]       cfg_wdata_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [FUNC_W-1:0]       func_i,
  input  wire logic [IDX_W-1:0]        row_i,
  input  wire logic [IDX_W-1:0]        col_i,
  input  wire logic signed [VAL_W-1:0] value_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [IDX_W-1:0]             result_col_o,
  output logic signed [RES_W-1:0]      result_value_o,
  output logic                         last_o
);

  localparam int EW        = (ELEM_W < VAL_W) ? ELEM_W : VAL_W;
  localparam int RW        = $clog2(MAX_N);
  localparam int XW        = (RW > IDX_W) ? RW : IDX_W;
  localparam int AW        = 2 * RW;
  localparam int DEPTH     = MAX_N * (2 ** RW);
  localparam int ROW_LIMIT = (MAX_N < (2 ** IDX_W)) ? MAX_N : (2 ** IDX_W);
  localparam int ACC_W     = 2 * EW + 6;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MAC   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_e;

  state_e                   state_q, state_d;
  logic [SIZE_W-1:0]        size_q;
  logic [SIZE_W-1:0]        n_q, n_d;
  logic [SIZE_W-1:0]        eff_n;
  logic [IDX_W-1:0]         row_q, row_d;
  logic [IDX_W-1:0]         j_q, j_d;
  logic [IDX_W-1:0]         k_q, k_d;
  logic                     out_valid_q, out_valid_d;
  logic [IDX_W-1:0]         out_col_q;
  logic signed [RES_W-1:0]  out_value_q;
  logic                     out_last_q;
  logic                     out_load;
  logic                     out_free;
  logic                     in_xfer;
  logic                     row_ok;
  logic                     wr_inside;
  logic                     we_a, we_b;
  logic                     k_last, j_last;
  logic [XW-1:0]            row_x, col_x, rq_x, k_x, j_x;
  logic [AW-1:0]            waddr;
  logic [AW-1:0]            raddr_a, raddr_b;
  logic signed [EW-1:0]     rd_a, rd_b;
  mac_ctrl_t                mac_ctrl;
  logic signed [ACC_W-1:0]  mac_acc;
  logic                     mac_done;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Clamp the configured size into the supported range
  always_comb begin
    if (size_q == '0) begin
      eff_n = SIZE_W'(1);
    end else if (size_q > SIZE_W'(ROW_LIMIT)) begin
      eff_n = SIZE_W'(ROW_LIMIT);
    end else begin
      eff_n = size_q;
    end
  end

  assign row_ok = ({1'b0, row_i} < eff_n);

  // Element writes
  assign row_x     = XW'(row_i);
  assign col_x     = XW'(col_i);
  assign wr_inside = ({1'b0, row_x} < (XW + 1)'(MAX_N)) &&
                     ({1'b0, col_x} < (XW + 1)'(MAX_N));
  assign we_a      = in_xfer && (func_i == FUNC_WR_A) && wr_inside;
  assign we_b      = in_xfer && (func_i == FUNC_WR_B) && wr_inside;
  assign waddr     = {row_x[RW-1:0], col_x[RW-1:0]};

  // Operand reads: A walks along the row, B down the column
  assign rq_x    = XW'(row_q);
  assign k_x     = XW'(k_q);
  assign j_x     = XW'(j_q);
  assign raddr_a = {rq_x[RW-1:0], k_x[RW-1:0]};
  assign raddr_b = {k_x[RW-1:0], j_x[RW-1:0]};

  mme_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (value_i[EW-1:0]),
    .raddr_i (raddr_a),
    .rdata_o (rd_a)
  );

  mme_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (value_i[EW-1:0]),
    .raddr_i (raddr_b),
    .rdata_o (rd_b)
  );

  assign k_last = ({1'b0, k_q} == (n_q - SIZE_W'(1)));
  assign j_last = ({1'b0, j_q} == (n_q - SIZE_W'(1)));

  assign mac_ctrl.valid = (state_q == S_MAC);
  assign mac_ctrl.first = (k_q == '0);
  assign mac_ctrl.last  = k_last;

  // Sum of at most 64 products stays inside ACC_W, itself within 40 bits,
  // so the sum never overflows and needs no saturation.
  mme_mac #(
    .EW (EW)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (rd_a),
    .b_i    (rd_b),
    .acc_o  (mac_acc),
    .done_o (mac_done)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d  = state_q;
    n_d      = n_q;
    row_d    = row_q;
    j_d      = j_q;
    k_d      = k_q;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_xfer && (func_i == FUNC_ROW) && row_ok) begin
          n_d     = eff_n;
          row_d   = row_i;
          j_d     = '0;
          k_d     = '0;
          state_d = S_MAC;
        end
      end
      S_MAC: begin
        if (k_last) begin
          state_d = S_DRAIN;
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        if (mac_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold the sum until the output register is free
        if (out_free) begin
          out_load = 1'b1;
          k_d      = '0;
          if (j_last) begin
            state_d = S_IDLE;
          end else begin
            j_d     = j_q + IDX_W'(1);
            state_d = S_MAC;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      size_q      <= SIZE_W'(SIZE_RESET);
      n_q         <= SIZE_W'(1);
      row_q       <= '0;
      j_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      row_q       <= row_d;
      j_q         <= j_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_col_q   <= j_q;
      out_value_q <= RES_W'(mac_acc);
      out_last_q  <= j_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_col_o   = out_col_q;
  assign result_value_o = out_value_q;
  assign last_o         = out_last_q;

`ifndef SYNTHESIS
  a_row_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (func_i == FUNC_ROW) && row_ok) |=> (state_q == S_MAC))
    else $error("accepted row request did not start the sequencer");

  a_done_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> (state_q == S_DRAIN))
    else $error("column sum finished outside the drain phase");

  a_last_ends_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && j_last) |=> ((state_q == S_IDLE) && out_valid_o && last_o))
    else $error("final column did not end the row with last set");
`endif

endmodule

`default_nettype wire
